[src/bba_pkg.sv]
// Shared types, constants and helper functions for the buddy block allocator.
// Used by bba_ctrl, bba_datapath, buddy_block_allocator_unit and the testbench; no dependencies.
package bba_pkg;

   // pool geometry, fixed by the 6-bit address fields
   localparam int ADDR_W     = 6;
   localparam int SIZE_W     = 7;
   localparam int ORDER_W    = 3;
   localparam int POOL_UNITS = 1 << ADDR_W;
   localparam int NUM_ORDERS = ADDR_W + 1;
   localparam logic [ORDER_W-1:0] POOL_ORDER = ORDER_W'(ADDR_W);

   // action codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // datapath command codes
   typedef logic [2:0] op_type;
   localparam op_type OP_NONE   = 3'd0;
   localparam op_type OP_LOAD   = 3'd1;
   localparam op_type OP_DECODE = 3'd2;
   localparam op_type OP_SEARCH = 3'd3;
   localparam op_type OP_SPLIT  = 3'd4;
   localparam op_type OP_MERGE  = 3'd5;
   localparam op_type OP_RESP   = 3'd6;

   typedef logic [POOL_UNITS-1:0] row_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic action;      // ACT_FREE when the held item is a free
      logic oversize;    // decoded order is above the pool order
      logic hit;         // a free block exists in the current order
      logic k_eq_order;  // current order equals the request order
      logic at_top;      // current order is the pool order
      logic split_last;  // next split lands on the request order
      logic merge_go;    // buddy is free and top not reached
      logic rsp_free;    // output register can take a result
   } status_type;

   // log2 of the size rounded up to a power of two; size 0 gives 0
   function automatic logic [ORDER_W-1:0] order_of(input logic [SIZE_W-1:0] size);
      logic [ORDER_W-1:0] ord;
      ord = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (size > SIZE_W'(1 << i)) begin
            ord = ORDER_W'(i + 1);
         end
      end
      return ord;
   endfunction

   // mask of the low 'order' address bits, all ones above the pool order
   function automatic logic [ADDR_W-1:0] low_mask(input logic [ORDER_W-1:0] order);
      logic [ADDR_W-1:0] m;
      m = '0;
      for (int i = 0; i < ADDR_W; i++) begin
         if (ORDER_W'(i) < order) begin
            m[i] = 1'b1;
         end
      end
      return m;
   endfunction

   // free bits that may start a block of the given order
   function automatic row_type align_mask(input logic [ORDER_W-1:0] order);
      row_type m;
      for (int i = 0; i < POOL_UNITS; i++) begin
         m[i] = ((ADDR_W'(i) & low_mask(order)) == '0);
      end
      return m;
   endfunction

endpackage

[src/bba_ctrl.sv]
// Sequencer of the buddy block allocator: walks decode, search, split or merge
// and response steps. Depends on bba_pkg for command and status types.
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bba_pkg::status_type    status,
   output bba_pkg::cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_SPLIT  = 3'd3;
   localparam logic [2:0] ST_MERGE  = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and command
   always_comb begin
      state_in   = state_ff;
      cmd.op     = bba_pkg::OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = bba_pkg::OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.op = bba_pkg::OP_DECODE;
            priority if (status.oversize) begin
               state_in = ST_RESP;
            end else if (status.action == bba_pkg::ACT_FREE) begin
               state_in = ST_MERGE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.op = bba_pkg::OP_SEARCH;
            priority if (status.hit) begin
               state_in = status.k_eq_order ? ST_RESP : ST_SPLIT;
            end else if (status.at_top) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SPLIT: begin
            cmd.op = bba_pkg::OP_SPLIT;
            if (status.split_last) begin
               state_in = ST_RESP;
            end
         end
         ST_MERGE: begin
            cmd.op = bba_pkg::OP_MERGE;
            if (!status.merge_go) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.op   = bba_pkg::OP_RESP;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/bba_datapath.sv]
// Datapath of the buddy block allocator: free map, item registers, order walk
// and output register. Depends on bba_pkg; driven by bba_ctrl commands.
module bba_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  bba_pkg::cmd_type              cmd,
   output bba_pkg::status_type           status,
   input  logic                          in_action,
   input  logic [bba_pkg::SIZE_W-1:0]    in_size,
   input  logic [bba_pkg::ADDR_W-1:0]    in_addr,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]    rsp_addr,
   output logic [bba_pkg::ORDER_W-1:0]   rsp_order
);

   bba_pkg::row_type                 free_map_ff [bba_pkg::NUM_ORDERS];
   bba_pkg::row_type                 free_map_in [bba_pkg::NUM_ORDERS];
   logic                             action_ff, action_in;
   logic [bba_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic [bba_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [bba_pkg::ORDER_W-1:0]      order_ff, order_in;
   logic [bba_pkg::ORDER_W-1:0]      k_ff, k_in;
   logic                             nospace_ff, nospace_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_status_ff, rsp_status_in;
   logic [bba_pkg::ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [bba_pkg::ORDER_W-1:0]      rsp_order_ff, rsp_order_in;

   logic [bba_pkg::ORDER_W-1:0]      dec_order;
   bba_pkg::row_type                 row_k;
   bba_pkg::row_type                 cand;
   logic                             hit;
   logic [bba_pkg::ADDR_W-1:0]       low_idx;
   logic [bba_pkg::ADDR_W-1:0]       k_bit;
   logic [bba_pkg::ADDR_W-1:0]       buddy_addr;
   logic [bba_pkg::ADDR_W-1:0]       half_addr;
   logic                             merge_go;
   logic [bba_pkg::ORDER_W-1:0]      k_dn;

   // per-order lookups on the current row
   always_comb begin
      dec_order  = bba_pkg::order_of(size_ff);
      row_k      = free_map_ff[k_ff];
      cand       = row_k & bba_pkg::align_mask(k_ff);
      hit        = |cand;
      low_idx    = '0;
      for (int i = bba_pkg::POOL_UNITS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            low_idx = bba_pkg::ADDR_W'(i);
         end
      end
      k_dn       = k_ff - 3'd1;
      k_bit      = bba_pkg::ADDR_W'(1) << k_ff;
      buddy_addr = addr_ff ^ k_bit;
      half_addr  = addr_ff | (bba_pkg::ADDR_W'(1) << k_dn);
      merge_go   = (k_ff != bba_pkg::POOL_ORDER) && row_k[buddy_addr];
   end

   // status toward the sequencer
   always_comb begin
      status.action     = action_ff;
      status.oversize   = (dec_order > bba_pkg::POOL_ORDER);
      status.hit        = hit;
      status.k_eq_order = (k_ff == order_ff);
      status.at_top     = (k_ff == bba_pkg::POOL_ORDER);
      status.split_last = (k_dn == order_ff);
      status.merge_go   = merge_go;
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   // next values per command
   always_comb begin
      free_map_in   = free_map_ff;
      action_in     = action_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      order_in      = order_ff;
      k_in          = k_ff;
      nospace_in    = nospace_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (cmd.op)
         bba_pkg::OP_NONE: begin
         end
         bba_pkg::OP_LOAD: begin
            action_in  = in_action;
            size_in    = in_size;
            addr_in    = in_addr;
            nospace_in = 1'b0;
         end
         bba_pkg::OP_DECODE: begin
            order_in   = dec_order;
            k_in       = dec_order;
            addr_in    = addr_ff & ~bba_pkg::low_mask(dec_order);
            nospace_in = (action_ff == bba_pkg::ACT_ALLOC) &&
                         (dec_order > bba_pkg::POOL_ORDER);
         end
         bba_pkg::OP_SEARCH: begin
            // take the lowest free block, move up one order, or flag no space at the top order
            priority if (hit) begin
               free_map_in[k_ff][low_idx] = 1'b0;
               addr_in = low_idx;
            end else if (k_ff == bba_pkg::POOL_ORDER) begin
               nospace_in = 1'b1;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         bba_pkg::OP_SPLIT: begin
            // free the upper half, keep the lower half
            free_map_in[k_dn][half_addr] = 1'b1;
            k_in = k_dn;
         end
         bba_pkg::OP_MERGE: begin
            if (merge_go) begin
               free_map_in[k_ff][buddy_addr] = 1'b0;
               addr_in = addr_ff & ~k_bit;
               k_in    = k_ff + 3'd1;
            end else begin
               free_map_in[k_ff][addr_ff] = 1'b1;
            end
         end
         bba_pkg::OP_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = nospace_ff;
            rsp_addr_in   = ((action_ff == bba_pkg::ACT_ALLOC) && !nospace_ff) ?
                            addr_ff : '0;
            rsp_order_in  = order_ff;
         end
         default: begin
         end
      endcase
   end

   // control and free map registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < bba_pkg::NUM_ORDERS; r++) begin
            free_map_ff[r] <= '0;
         end
         free_map_ff[bba_pkg::POOL_ORDER][0] <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_map_ff  <= free_map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      order_ff      <= order_in;
      k_ff          <= k_in;
      nospace_ff    <= nospace_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_order_ff  <= rsp_order_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_order  = rsp_order_ff;

endmodule

[src/buddy_block_allocator_unit.sv]
// Buddy block allocator over a 64-unit pool, orders 0 to 6; one item at a time.
// Each request takes a decode step, then a search up the orders from the request order
// and a split for each order back down to it, or a merge step for each order until the
// buddy is busy or the top is reached, then a load of the output register; an oversized
// request skips the walk. req_tready returns as the result is loaded, so no request is
// taken while an item is in flight; the load waits on rsp_tready for the last result.
// Reset: only the whole pool is free, output register empty, sequencer idle.
module buddy_block_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [6:0] request_size, [12:7] block_address, [15:13] zero
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] granted_address, [8:6] granted_order, [15:9] zero
   output logic        rsp_tuser    // [0] status
);

   bba_pkg::cmd_type                cmd;
   bba_pkg::status_type             status;
   logic [bba_pkg::ADDR_W-1:0]      rsp_addr;
   logic [bba_pkg::ORDER_W-1:0]     rsp_order;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bba_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_action  (req_tuser),
      .in_size    (req_tdata[6:0]),
      .in_addr    (req_tdata[12:7]),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_addr   (rsp_addr),
      .rsp_order  (rsp_order)
   );

   // pack the result
   assign rsp_tdata = {7'd0, rsp_order, rsp_addr};

`ifndef SYNTHESIS
   // one item in flight: no request right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an item is in flight");

   // a no-space result carries address zero
   a_nospace_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[5:0] == '0))
      else $error("no-space result with nonzero address");

   // a granted block is aligned to its order
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[5:0] & bba_pkg::low_mask(rsp_tdata[8:6])) == '0))
      else $error("granted address not aligned to its order");
`endif

endmodule

[dv/buddy_block_allocator_unit_test.sv]
// Self-checking testbench for buddy_block_allocator_unit: directed table, then random
// allocate/free traffic checked against an in-bench model of the buddy free lists.
// Depends on bba_pkg and the unit; reads no files.
module buddy_block_allocator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   TOP_ORDER     = int'(bba_pkg::POOL_ORDER);
   localparam int   RANDOM_ITEMS  = 600;
   localparam int   CYCLE_LIMIT   = 200000;
   localparam int   DRAIN_CYCLES  = 40;
   localparam logic STAT_DONE     = 1'b0;
   localparam logic STAT_NO_SPACE = 1'b1;
   localparam logic FIXED         = 1'b1;   // expectation typed into the table
   localparam logic PREDICTED     = 1'b0;   // expectation taken from the model

   typedef struct packed {
      logic                        status;
      logic [bba_pkg::ADDR_W-1:0]  addr;
      logic [bba_pkg::ORDER_W-1:0] order;
   } grant_type;

   typedef struct packed {
      logic                        action;
      logic [bba_pkg::SIZE_W-1:0]  size;
      logic [bba_pkg::ADDR_W-1:0]  where;
   } request_type;

   typedef struct packed {
      logic                        action;
      logic [bba_pkg::SIZE_W-1:0]  size;
      logic [bba_pkg::ADDR_W-1:0]  where;
      logic                        typed;
      logic                        status;
      logic [bba_pkg::ADDR_W-1:0]  addr;
      logic [bba_pkg::ORDER_W-1:0] order;
   } plan_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_style_type;

   // directed table: extremes, oversize, nothing fits, double and misaligned frees, merges
   localparam plan_row_type PLAN [25] = '{
      '{bba_pkg::ACT_ALLOC, 7'd0,   6'd63, FIXED,     STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_ALLOC, 7'd1,   6'd0,  FIXED,     STAT_DONE,     6'd1,  3'd0},
      '{bba_pkg::ACT_ALLOC, 7'd127, 6'd0,  FIXED,     STAT_NO_SPACE, 6'd0,  3'd7},
      '{bba_pkg::ACT_ALLOC, 7'd64,  6'd0,  FIXED,     STAT_NO_SPACE, 6'd0,  3'd6},
      '{bba_pkg::ACT_ALLOC, 7'd65,  6'd0,  FIXED,     STAT_NO_SPACE, 6'd0,  3'd7},
      '{bba_pkg::ACT_FREE,  7'd127, 6'd63, FIXED,     STAT_DONE,     6'd0,  3'd7},
      '{bba_pkg::ACT_FREE,  7'd1,   6'd1,  FIXED,     STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_FREE,  7'd1,   6'd1,  FIXED,     STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_FREE,  7'd0,   6'd0,  FIXED,     STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_ALLOC, 7'd64,  6'd0,  FIXED,     STAT_DONE,     6'd0,  3'd6},
      '{bba_pkg::ACT_ALLOC, 7'd1,   6'd0,  FIXED,     STAT_NO_SPACE, 6'd0,  3'd0},
      '{bba_pkg::ACT_FREE,  7'd64,  6'd63, FIXED,     STAT_DONE,     6'd0,  3'd6},
      '{bba_pkg::ACT_ALLOC, 7'd3,   6'd0,  FIXED,     STAT_DONE,     6'd0,  3'd2},
      '{bba_pkg::ACT_ALLOC, 7'd5,   6'd0,  FIXED,     STAT_DONE,     6'd8,  3'd3},
      '{bba_pkg::ACT_ALLOC, 7'd32,  6'd0,  FIXED,     STAT_DONE,     6'd32, 3'd5},
      '{bba_pkg::ACT_ALLOC, 7'd2,   6'd0,  PREDICTED, STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_ALLOC, 7'd17,  6'd0,  FIXED,     STAT_NO_SPACE, 6'd0,  3'd5},
      '{bba_pkg::ACT_FREE,  7'd16,  6'd21, PREDICTED, STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_FREE,  7'd8,   6'd8,  PREDICTED, STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_FREE,  7'd2,   6'd4,  PREDICTED, STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_FREE,  7'd4,   6'd0,  PREDICTED, STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_FREE,  7'd32,  6'd32, PREDICTED, STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_ALLOC, 7'd42,  6'd21, PREDICTED, STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_FREE,  7'd64,  6'd0,  PREDICTED, STAT_DONE,     6'd0,  3'd0},
      '{bba_pkg::ACT_ALLOC, 7'd8,   6'd0,  PREDICTED, STAT_DONE,     6'd0,  3'd0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [6:0] request_size, [12:7] block_address, [15:13] zero
   logic        req_tuser  = 1'b0; // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [5:0] granted_address, [8:6] granted_order, [15:9] zero
   logic        rsp_tuser;         // [0] status

   bba_pkg::row_type free_rows [bba_pkg::NUM_ORDERS];
   grant_type    pending_grants [$];
   int           live_addr [$];
   int           live_order [$];
   int           mismatches   = 0;
   int           cycle_count  = 0;
   int           burst_left   = 0;
   int           n_granted    = 0;
   int           n_refused    = 0;
   int           n_freed      = 0;
   int           ready_tick   = 0;
   rx_style_type rx_style     = RX_OPEN;

   buddy_block_allocator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // log2 of the size rounded up to a power of two, saturating at 8
   function automatic int size_to_order(input logic [bba_pkg::SIZE_W-1:0] size);
      int k;
      k = 0;
      while (k < 8 && (1 << k) < int'(size)) begin
         k++;
      end
      return k;
   endfunction

   // update the free lists for one request and return the grant it produces
   function automatic grant_type predict_grant(input request_type r);
      grant_type g;
      int        ord;
      int        j;
      int        a;
      int        k;
      bit        found;
      ord     = size_to_order(r.size);
      g.status = STAT_DONE;
      g.addr   = '0;
      g.order  = bba_pkg::ORDER_W'(ord);
      if (r.action == bba_pkg::ACT_ALLOC) begin
         if (ord > TOP_ORDER) begin
            g.status = STAT_NO_SPACE;
            return g;
         end
         // smallest sufficient order, lowest address first
         found = 0;
         a     = 0;
         j     = ord;
         while (!found && j <= TOP_ORDER) begin
            a = 0;
            while (!found && a < bba_pkg::POOL_UNITS) begin
               if (free_rows[j][a]) found = 1;
               else a += (1 << j);
            end
            if (!found) j++;
         end
         if (!found) begin
            g.status = STAT_NO_SPACE;
            return g;
         end
         // split down, releasing each upper half
         free_rows[j][a] = 1'b0;
         for (k = j; k > ord; k--) begin
            free_rows[k-1][a + (1 << (k-1))] = 1'b1;
         end
         g.addr = bba_pkg::ADDR_W'(a);
      end else if (ord <= TOP_ORDER) begin
         // realign, then merge with free buddies toward the top
         a = int'(r.where) & ~((1 << ord) - 1);
         k = ord;
         while (k < TOP_ORDER && free_rows[k][a ^ (1 << k)]) begin
            free_rows[k][a ^ (1 << k)] = 1'b0;
            a = a & ~(1 << k);
            k++;
         end
         free_rows[k][a] = 1'b1;
      end
      return g;
   endfunction

   // some size that rounds to the given order
   function automatic logic [bba_pkg::SIZE_W-1:0] size_for_order(input int ord);
      if (ord == 0) return bba_pkg::SIZE_W'($urandom_range(1));
      return bba_pkg::SIZE_W'($urandom_range(1 << ord, (1 << (ord - 1)) + 1));
   endfunction

   // mostly well-formed traffic: allocate, free what is held, a little noise
   function automatic request_type pick_request(input bit draining);
      request_type r;
      int          roll;
      int          idx;
      int          ord;
      roll    = $urandom_range(99);
      r.where = bba_pkg::ADDR_W'($urandom);
      if (draining && live_addr.size() != 0) roll = 60;
      if (roll < 50 || (roll < 92 && live_addr.size() == 0)) begin
         r.action = bba_pkg::ACT_ALLOC;
         roll     = $urandom_range(99);
         if (roll < 75) r.size = size_for_order($urandom_range(3));
         else if (roll < 95) r.size = size_for_order($urandom_range(6, 4));
         else r.size = bba_pkg::SIZE_W'($urandom_range(127, 65));
      end else if (roll < 92) begin
         idx      = $urandom_range(live_addr.size() - 1);
         ord      = live_order[idx];
         r.action = bba_pkg::ACT_FREE;
         r.size   = size_for_order(ord);
         // leave junk in the low bits now and then; the block must realign
         if ($urandom_range(3) == 0)
            r.where = bba_pkg::ADDR_W'(live_addr[idx] | ($urandom & ((1 << ord) - 1)));
         else
            r.where = bba_pkg::ADDR_W'(live_addr[idx]);
         live_addr.delete(idx);
         live_order.delete(idx);
      end else begin
         r.action = $urandom_range(1) ? bba_pkg::ACT_FREE : bba_pkg::ACT_ALLOC;
         r.size   = bba_pkg::SIZE_W'($urandom_range(127));
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
               what, cycle_count, got, want);
      mismatches++;
   endtask

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_request(input request_type req, input logic typed,
                               input grant_type fixed_grant);
      grant_type g;
      // idle between bursts
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
         burst_left = ($urandom_range(3) == 0) ? 60 : $urandom_range(24, 1);
      end
      burst_left--;
      g = predict_grant(req);
      if (req.action == bba_pkg::ACT_FREE) n_freed++;
      else if (g.status == STAT_NO_SPACE) n_refused++;
      else begin
         n_granted++;
         live_addr.push_back(int'(g.addr));
         live_order.push_back(int'(g.order));
      end
      pending_grants.push_back(typed ? fixed_grant : g);
      req_tdata  <= {3'b000, req.where, req.size};
      req_tuser  <= req.action;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // receiver back-pressure, switching style every so often
   always @(negedge clock) begin
      ready_tick++;
      if (ready_tick % 97 == 0) rx_style = rx_style_type'($urandom_range(3));
      case (rx_style)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(1));
         RX_SPARSE: rsp_tready <= (ready_tick % 4 == 0);
         default:   rsp_tready <= (ready_tick % 16 >= 12);
      endcase
   end

   // check each result transfer against the oldest expectation
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_grants.size() == 0) begin
            flag_mismatch("result with none pending", rsp_tdata, '0);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_tuser !== want.status)
               flag_mismatch("status", 16'(rsp_tuser), 16'(want.status));
            if (rsp_tdata[5:0] !== want.addr)
               flag_mismatch("granted_address", 16'(rsp_tdata[5:0]), 16'(want.addr));
            if (rsp_tdata[8:6] !== want.order)
               flag_mismatch("granted_order", 16'(rsp_tdata[8:6]), 16'(want.order));
         end
      end
   end

   // hard stop for a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, pending_grants.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      request_type req;
      grant_type   fixed_grant;
      bit          draining;
      draining = 0;
      foreach (free_rows[i]) free_rows[i] = '0;
      free_rows[TOP_ORDER][0] = 1'b1;

      // hold reset, release at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (PLAN[i]) begin
         req         = '{PLAN[i].action, PLAN[i].size, PLAN[i].where};
         fixed_grant = '{PLAN[i].status, PLAN[i].addr, PLAN[i].order};
         send_request(req, PLAN[i].typed, fixed_grant);
      end

      // random traffic with periodic drains and full hold-offs
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 100) draining = 1;
         if (live_addr.size() == 0) draining = 0;
         if (n == 200 || n == 450) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (pending_grants.size() != 0);
         end
         send_request(pick_request(draining), PREDICTED, '0);
      end

      // wait out the remaining results, then a quiet tail
      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("requests: %0d grants, %0d refused for no space, %0d frees",
               n_granted, n_refused, n_freed);
      $display("checked in %0d cycles with %0d mismatches", cycle_count, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
